FILE: hdl/lsc_pkg.sv
// Link session controller: shared types, codes and the legal-move table.
// Used by every module of the block; no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none

package lsc_pkg;

  localparam int DIGEST_MAX_BYTES_DEF = 32;
  localparam logic [7:0] MAJOR_MAX = 8'd15;

  localparam int IN_DATA_W  = 96;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [3:0] {
    ST_IDLE = 4'd0,
    ST_DISC = 4'd1,
    ST_CAPS = 4'd2,
    ST_NEGO = 4'd3,
    ST_ESTB = 4'd4,
    ST_ADPT = 4'd5,
    ST_HOFF = 4'd6,
    ST_FALL = 4'd7,
    ST_CLSD = 4'd8
  } link_state_t;

  typedef enum logic [1:0] {
    KIND_MOVE    = 2'd0,
    KIND_RESET   = 2'd1,
    KIND_INSTALL = 2'd2,
    KIND_AUTH    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_BAD_STATE = 3'd1,
    STS_RANGE     = 3'd2,
    STS_VERSION   = 3'd3,
    STS_NO_CTX    = 3'd4,
    STS_MISMATCH  = 3'd5
  } status_t;

  // At most one access to the digest store per accepted byte beat.
  typedef struct packed {
    logic       en;
    logic       wr;
    logic [7:0] wdata;
  } dig_req_t;

  // Legal targets for each source state, one bit per target (bit 0 = idle).
  function automatic logic [8:0] legal_moves(link_state_t src);
    logic [8:0] m;
    unique case (src)
      ST_IDLE: m = 9'b1_0000_0010;
      ST_DISC: m = 9'b1_0000_0101;
      ST_CAPS: m = 9'b1_0000_1001;
      ST_NEGO: m = 9'b1_0001_0001;
      ST_ESTB: m = 9'b1_1110_0001;
      ST_ADPT: m = 9'b1_1101_0001;
      ST_HOFF: m = 9'b1_0001_0001;
      ST_FALL: m = 9'b1_0001_0011;
      ST_CLSD: m = 9'b0_0000_0001;
      default: m = 9'b0_0000_0000;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/lsc_digest_store.sv
// Digest byte store: two banks per byte position, with per-position pointers
// to the active and the staged copy. Depends on lsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsc_digest_store #(
  parameter int   DEPTH = lsc_pkg::DIGEST_MAX_BYTES_DEF,
  localparam int  IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire lsc_pkg::dig_req_t req,
  input  wire logic [IW-1:0]    idx,
  input  wire logic             commit,
  output logic [7:0]            rdata
);

  logic [7:0]       mem [2][DEPTH];
  logic [7:0]       rdata_r;
  logic [DEPTH-1:0] act_r;
  logic [DEPTH-1:0] act_nxt;
  logic [DEPTH-1:0] stage_r;
  logic [DEPTH-1:0] stage_nxt;
  logic             bank;

  // An install commit in this cycle makes the staged bytes active at once,
  // so a same-cycle access already sees the new mapping.
  always_comb begin
    act_nxt   = commit ? stage_r : act_r;
    bank      = req.wr ? ~act_nxt[idx] : act_nxt[idx];
    stage_nxt = stage_r;
    if (req.en && req.wr) begin
      stage_nxt[idx] = ~act_nxt[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r   <= '0;
      stage_r <= '0;
    end else begin
      act_r   <= act_nxt;
      stage_r <= stage_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.en && req.wr) begin
      mem[bank][idx] <= req.wdata;
    end
    if (req.en && !req.wr) begin
      rdata_r <= mem[bank][idx];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hdl/link_session_controller_unit.sv
// Link session controller top level: link state, context checks, stream ports.
// Depends on lsc_pkg and lsc_digest_store.
//
// Takes one beat per clock on the input stream; a beat that answers (a transition, a
// reset, or the last byte of an install or authorize run) raises out_tvalid with its
// result from the output register once it leaves the compare stage. Digest bytes live
// in a one-port synchronous store read in the accept cycle; the compare and all checks
// run in the following cycle, with the bank mapping forwarded from an install that
// commits in that cycle. A beat that answers holds in the compare stage while the output
// register is full and out_tready is low, so input stalls only once both are occupied.
// No clearing pass after reset: bytes never written read as unknown until installed.
`timescale 1ns / 1ps
`default_nettype none

module link_session_controller_unit #(
  parameter int DIGEST_MAX_BYTES = lsc_pkg::DIGEST_MAX_BYTES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // tdata: target_state[3:0], key_major[11:4], key_id[43:12], key_generation[75:44],
  //        key_digest_size[83:76], digest_byte[91:84], zero pad [95:92]
  input  wire logic [lsc_pkg::IN_DATA_W-1:0]  in_tdata,
  // tuser: kind[1:0]
  input  wire logic [lsc_pkg::IN_USER_W-1:0]  in_tuser,
  input  wire logic                           in_tlast,   // digest_last
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // tdata: status[2:0], current_state[6:3], context_present[7]
  output logic [lsc_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  input  wire logic                           cfg_wr_en,
  input  wire logic [15:0]                    cfg_wr_data
);

  localparam int         IW   = (DIGEST_MAX_BYTES > 1) ? $clog2(DIGEST_MAX_BYTES) : 1;
  localparam logic [8:0] MAX9 = 9'(DIGEST_MAX_BYTES);

  // input beat fields
  lsc_pkg::kind_t in_kind;
  logic           in_acc;
  logic           in_is_byte;

  // accept-stage registers
  logic                 p1_valid_r, p1_valid_nxt;
  lsc_pkg::kind_t       p1_kind_r;
  logic [3:0]           p1_tgt_r;
  logic [7:0]           p1_major_r;
  logic [31:0]          p1_id_r;
  logic [31:0]          p1_gen_r;
  logic [7:0]           p1_size_r;
  logic [7:0]           p1_byte_r;
  logic                 p1_last_r;
  logic [7:0]           p1_pos_r;
  logic                 p1_fire;
  logic                 has_res;

  // block state
  lsc_pkg::link_state_t lstate_r, lstate_nxt;
  logic                 ctx_valid_r, ctx_valid_nxt;
  logic [3:0]           act_major_r, act_major_nxt;
  logic [31:0]          act_id_r, act_id_nxt;
  logic [31:0]          act_gen_r, act_gen_nxt;
  logic [7:0]           act_len_r, act_len_nxt;
  logic [7:0]           run_idx_r, run_idx_nxt;
  logic                 run_mm_r, run_mm_nxt;
  logic [15:0]          mask_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_data_r;

  // check logic
  lsc_pkg::dig_req_t    dig_req;
  logic [7:0]           dig_rdata;
  logic                 commit;
  logic                 drop;
  lsc_pkg::status_t     status;
  logic [8:0]           count;
  logic                 size_ok;
  logic                 byte_mm;
  logic                 mm_all;
  logic [15:0]          lm16;

  assign in_kind    = lsc_pkg::kind_t'(in_tuser);
  assign in_acc     = in_tvalid && in_tready;
  assign in_is_byte = (in_kind == lsc_pkg::KIND_INSTALL) || (in_kind == lsc_pkg::KIND_AUTH);

  assign has_res = (p1_kind_r == lsc_pkg::KIND_MOVE) || (p1_kind_r == lsc_pkg::KIND_RESET) ||
                   p1_last_r;
  assign p1_fire   = p1_valid_r && (!has_res || !out_valid_r || out_tready);
  assign in_tready = !p1_valid_r || p1_fire;

  // accept stage: run counter and store access
  always_comb begin
    run_idx_nxt = run_idx_r;
    if (in_acc && in_is_byte) begin
      if (in_tlast) begin
        run_idx_nxt = '0;
      end else if (run_idx_r != 8'hFF) begin
        run_idx_nxt = run_idx_r + 8'd1;
      end
    end
    p1_valid_nxt  = in_acc ? 1'b1 : (p1_fire ? 1'b0 : p1_valid_r);
    dig_req.en    = in_acc && in_is_byte && ({1'b0, run_idx_r} < MAX9);
    dig_req.wr    = (in_kind == lsc_pkg::KIND_INSTALL);
    dig_req.wdata = in_tdata[91:84];
  end

  lsc_digest_store #(
    .DEPTH (DIGEST_MAX_BYTES)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (dig_req),
    .idx    (run_idx_r[IW-1:0]),
    .commit (p1_fire && commit),
    .rdata  (dig_rdata)
  );

  // check stage
  always_comb begin
    count   = {1'b0, p1_pos_r} + 9'd1;
    size_ok = (p1_size_r != 8'd0) && ({1'b0, p1_size_r} <= MAX9);
    byte_mm = (p1_kind_r == lsc_pkg::KIND_AUTH) && ({1'b0, p1_pos_r} < MAX9) &&
              (p1_pos_r < act_len_r) && (dig_rdata != p1_byte_r);
    mm_all  = run_mm_r || byte_mm;
    lm16    = {7'd0, lsc_pkg::legal_moves(lstate_r)};

    lstate_nxt = lstate_r;
    run_mm_nxt = run_mm_r;
    status     = lsc_pkg::STS_OK;
    commit     = 1'b0;
    drop       = 1'b0;

    unique case (p1_kind_r)
      lsc_pkg::KIND_MOVE: begin
        if ((p1_tgt_r > 4'(lsc_pkg::ST_CLSD)) || !lm16[p1_tgt_r]) begin
          status = lsc_pkg::STS_BAD_STATE;
        end else begin
          lstate_nxt = lsc_pkg::link_state_t'(p1_tgt_r);
          if ((p1_tgt_r == 4'(lsc_pkg::ST_IDLE)) || (p1_tgt_r == 4'(lsc_pkg::ST_CLSD)) ||
              ((lstate_r == lsc_pkg::ST_FALL) && (p1_tgt_r == 4'(lsc_pkg::ST_DISC)))) begin
            drop = 1'b1;
          end
        end
      end
      lsc_pkg::KIND_RESET: begin
        lstate_nxt = lsc_pkg::ST_IDLE;
        drop       = 1'b1;
      end
      lsc_pkg::KIND_INSTALL: begin
        run_mm_nxt = p1_last_r ? 1'b0 : mm_all;
        if ((lstate_r == lsc_pkg::ST_IDLE) || (lstate_r == lsc_pkg::ST_DISC) ||
            (lstate_r == lsc_pkg::ST_CLSD)) begin
          status = lsc_pkg::STS_BAD_STATE;
        end else if (p1_major_r > lsc_pkg::MAJOR_MAX) begin
          status = lsc_pkg::STS_RANGE;
        end else if (!size_ok) begin
          status = lsc_pkg::STS_RANGE;
        end else if (!mask_r[p1_major_r[3:0]]) begin
          status = lsc_pkg::STS_VERSION;
        end else if (count != {1'b0, p1_size_r}) begin
          status = lsc_pkg::STS_RANGE;
        end else begin
          commit = p1_last_r;
        end
      end
      lsc_pkg::KIND_AUTH: begin
        run_mm_nxt = p1_last_r ? 1'b0 : mm_all;
        if (!ctx_valid_r) begin
          status = lsc_pkg::STS_NO_CTX;
        end else if ((act_len_r == 8'd0) || ({1'b0, act_len_r} > MAX9) || !size_ok ||
                     (p1_major_r != {4'd0, act_major_r}) || (p1_id_r != act_id_r) ||
                     (p1_gen_r != act_gen_r) || (p1_size_r != act_len_r) ||
                     (count != {1'b0, p1_size_r}) || mm_all) begin
          status = lsc_pkg::STS_MISMATCH;
        end
      end
      default: begin
        status = lsc_pkg::STS_OK;
      end
    endcase

    ctx_valid_nxt = ctx_valid_r;
    act_major_nxt = act_major_r;
    act_id_nxt    = act_id_r;
    act_gen_nxt   = act_gen_r;
    act_len_nxt   = act_len_r;
    if (drop) begin
      ctx_valid_nxt = 1'b0;
      act_major_nxt = '0;
      act_id_nxt    = '0;
      act_gen_nxt   = '0;
      act_len_nxt   = '0;
    end else if (commit) begin
      ctx_valid_nxt = 1'b1;
      act_major_nxt = p1_major_r[3:0];
      act_id_nxt    = p1_id_r;
      act_gen_nxt   = p1_gen_r;
      act_len_nxt   = p1_size_r;
    end

    if (p1_fire && has_res) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      lstate_r    <= lsc_pkg::ST_IDLE;
      ctx_valid_r <= 1'b0;
      act_major_r <= '0;
      act_id_r    <= '0;
      act_gen_r   <= '0;
      act_len_r   <= '0;
      run_idx_r   <= '0;
      run_mm_r    <= 1'b0;
      mask_r      <= 16'hFFFF;
      out_valid_r <= 1'b0;
    end else begin
      p1_valid_r  <= p1_valid_nxt;
      run_idx_r   <= run_idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        mask_r <= cfg_wr_data;
      end
      if (p1_fire) begin
        lstate_r    <= lstate_nxt;
        ctx_valid_r <= ctx_valid_nxt;
        act_major_r <= act_major_nxt;
        act_id_r    <= act_id_nxt;
        act_gen_r   <= act_gen_nxt;
        act_len_r   <= act_len_nxt;
        run_mm_r    <= run_mm_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      p1_kind_r  <= in_kind;
      p1_tgt_r   <= in_tdata[3:0];
      p1_major_r <= in_tdata[11:4];
      p1_id_r    <= in_tdata[43:12];
      p1_gen_r   <= in_tdata[75:44];
      p1_size_r  <= in_tdata[83:76];
      p1_byte_r  <= in_tdata[91:84];
      p1_last_r  <= in_tlast;
      p1_pos_r   <= run_idx_r;
    end
    if (p1_fire && has_res) begin
      out_data_r <= {ctx_valid_nxt, 4'(lstate_nxt), 3'(status)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

FILE: hdl/lsc_checker.sv
// Port-level checks for the link session controller, bound to the top level.
// Depends on lsc_pkg and link_session_controller_unit.
`timescale 1ns / 1ps
`default_nettype none

module lsc_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic [lsc_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready
);

  // status code stays inside the defined set
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2:0] <= 3'(lsc_pkg::STS_MISMATCH)))
    else $error("status code out of range");

  a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[6:3] <= 4'(lsc_pkg::ST_CLSD)))
    else $error("link state out of range");

  // a held context cannot survive idle, closed or discovered
  a_ctx_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[7]) |->
      ((out_tdata[6:3] != 4'(lsc_pkg::ST_IDLE)) &&
       (out_tdata[6:3] != 4'(lsc_pkg::ST_DISC)) &&
       (out_tdata[6:3] != 4'(lsc_pkg::ST_CLSD))))
    else $error("context present in a state that clears it");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result beat changed");

endmodule

bind link_session_controller_unit lsc_checker u_lsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire

FILE: dv/link_session_controller_unit_test.sv
// Self-checking testbench for link_session_controller_unit: link moves, context install and
// authorize runs, and the supported-major mask, checked beat by beat against a local predictor.
// Depends on lsc_pkg and the link_session_controller_unit RTL.
`timescale 1ns / 1ps

module link_session_controller_unit_test;
  import lsc_pkg::*;

  localparam int DIG_MAX      = DIGEST_MAX_BYTES_DEF;
  localparam int RANDOM_BEATS = 150;
  localparam int PHASE_BEATS  = 50;
  localparam int DRAIN_CYCLES = 8;

  // ways to spoil a presented key
  localparam int TW_NONE  = 0;
  localparam int TW_MAJOR = 1;
  localparam int TW_ID    = 2;
  localparam int TW_GEN   = 3;
  localparam int TW_SIZE  = 4;

  typedef struct {
    kind_t       kind;
    logic [3:0]  target;
    logic [7:0]  major;
    logic [31:0] id;
    logic [31:0] gen;
    logic [7:0]  size;
    logic [7:0]  dbyte;
    logic        last;
  } lsc_beat_t;

  typedef struct {
    status_t    status;
    logic [3:0] state;
    logic       ctx;
  } lsc_reply_t;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic [IN_USER_W-1:0]  in_tuser    = '0;
  logic                  in_tlast    = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b1;
  logic                  cfg_wr_en   = 1'b0;
  logic [15:0]           cfg_wr_data = 16'hFFFF;

  link_session_controller_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // predicted block state
  logic [15:0] m_mask  = 16'hFFFF;
  link_state_t m_state = ST_IDLE;
  logic        m_ctx   = 1'b0;
  logic [3:0]  m_major = '0;
  logic [31:0] m_id    = '0;
  logic [31:0] m_gen   = '0;
  logic [7:0]  m_len   = '0;
  logic [7:0]  m_dig   [DIG_MAX];
  logic [7:0]  m_stage [DIG_MAX];
  logic [7:0]  m_pos   = '0;
  logic        m_mis   = 1'b0;

  lsc_reply_t expected_replies[$];
  lsc_reply_t head_reply;

  bit gaps_en         = 1'b1;
  int beats_sent      = 0;
  int replies_checked = 0;
  int mask_writes     = 0;
  int installs_ok     = 0;
  int auths_ok        = 0;
  int mismatch_count  = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [8:0] reachable(link_state_t s);
    logic [8:0] exits;
    exits = (9'b1 << ST_IDLE) | (9'b1 << ST_CLSD);
    case (s)
      ST_IDLE: return (9'b1 << ST_DISC) | (9'b1 << ST_CLSD);
      ST_DISC: return exits | (9'b1 << ST_CAPS);
      ST_CAPS: return exits | (9'b1 << ST_NEGO);
      ST_NEGO: return exits | (9'b1 << ST_ESTB);
      ST_ESTB: return exits | (9'b1 << ST_ADPT) | (9'b1 << ST_HOFF) | (9'b1 << ST_FALL);
      ST_ADPT: return exits | (9'b1 << ST_ESTB) | (9'b1 << ST_HOFF) | (9'b1 << ST_FALL);
      ST_HOFF: return exits | (9'b1 << ST_ESTB);
      ST_FALL: return exits | (9'b1 << ST_ESTB) | (9'b1 << ST_DISC);
      ST_CLSD: return 9'b1 << ST_IDLE;
      default: return '0;
    endcase
  endfunction

  task automatic clear_context();
    m_ctx   = 1'b0;
    m_major = '0;
    m_id    = '0;
    m_gen   = '0;
    m_len   = '0;
    for (int i = 0; i < DIG_MAX; i++) m_dig[i] = '0;
  endtask

  // Advance the predicted state by one accepted beat; queue the reply if one is due.
  task automatic link_session_step(input lsc_beat_t b);
    lsc_reply_t r;
    logic [8:0] moves;
    int pos;
    int count;
    r.status = STS_OK;
    case (b.kind)
      KIND_MOVE: begin
        moves = reachable(m_state);
        if (b.target > 4'd8 || !moves[b.target]) begin
          r.status = STS_BAD_STATE;
        end else begin
          if (b.target == ST_IDLE || b.target == ST_CLSD ||
              (m_state == ST_FALL && b.target == ST_DISC))
            clear_context();
          m_state = link_state_t'(b.target);
        end
      end
      KIND_RESET: begin
        m_state = ST_IDLE;
        clear_context();
      end
      default: begin
        pos   = int'(m_pos);
        count = pos + 1;
        if (b.kind == KIND_INSTALL) begin
          if (pos < DIG_MAX) m_stage[pos] = b.dbyte;
        end else if (pos < m_len && pos < DIG_MAX && m_dig[pos] != b.dbyte) begin
          m_mis = 1'b1;
        end
        if (m_pos != 8'hFF) m_pos = m_pos + 8'd1;
        if (!b.last) return;
        if (b.kind == KIND_INSTALL) begin
          if (m_state == ST_IDLE || m_state == ST_DISC || m_state == ST_CLSD)
            r.status = STS_BAD_STATE;
          else if (b.major > MAJOR_MAX)
            r.status = STS_RANGE;
          else if (b.size == 0 || b.size > DIG_MAX)
            r.status = STS_RANGE;
          else if (!m_mask[b.major[3:0]])
            r.status = STS_VERSION;
          else if (count != b.size)
            r.status = STS_RANGE;
          else begin
            m_major = b.major[3:0];
            m_id    = b.id;
            m_gen   = b.gen;
            m_len   = b.size;
            for (int i = 0; i < DIG_MAX; i++) if (i < b.size) m_dig[i] = m_stage[i];
            m_ctx = 1'b1;
            installs_ok++;
          end
        end else begin
          if (!m_ctx)
            r.status = STS_NO_CTX;
          else if (m_len == 0 || m_len > DIG_MAX || b.size == 0 || b.size > DIG_MAX ||
                   b.major != {4'b0, m_major} || b.id != m_id || b.gen != m_gen ||
                   b.size != m_len || count != b.size || m_mis)
            r.status = STS_MISMATCH;
          else
            auths_ok++;
        end
        m_pos = '0;
        m_mis = 1'b0;
      end
    endcase
    r.state = m_state;
    r.ctx   = m_ctx;
    expected_replies.push_back(r);
  endtask

  // Result side: random backpressure, checked against the oldest expected reply.
  always @(negedge clk) begin
    out_tready <= !(gaps_en && $urandom_range(0, 99) < 28);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_replies.size() == 0) begin
        $error("result beat %h with no reply expected", out_tdata);
        mismatch_count++;
      end else begin
        head_reply = expected_replies.pop_front();
        replies_checked++;
        if (out_tdata[2:0] !== head_reply.status) begin
          $error("status: expected %0d, got %0d", head_reply.status, out_tdata[2:0]);
          mismatch_count++;
        end
        if (out_tdata[6:3] !== head_reply.state) begin
          $error("current_state: expected %0d, got %0d", head_reply.state, out_tdata[6:3]);
          mismatch_count++;
        end
        if (out_tdata[7] !== head_reply.ctx) begin
          $error("context_present: expected %0d, got %0d", head_reply.ctx, out_tdata[7]);
          mismatch_count++;
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input lsc_beat_t b);
    while (gaps_en && $urandom_range(0, 99) < 28) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata  <= {4'b0, b.dbyte, b.size, b.gen, b.id, b.major, b.target};
    in_tuser  <= b.kind;
    in_tlast  <= b.last;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    link_session_step(b);
    beats_sent++;
    @(negedge clk);
  endtask

  function automatic lsc_beat_t rand_beat(input kind_t k);
    lsc_beat_t b;
    b.kind   = k;
    b.target = 4'($urandom);
    b.major  = 8'($urandom);
    b.id     = $urandom;
    b.gen    = $urandom;
    b.size   = 8'($urandom);
    b.dbyte  = 8'($urandom);
    b.last   = 1'($urandom);
    return b;
  endfunction

  task automatic move_to(input logic [3:0] t);
    lsc_beat_t b;
    b = rand_beat(KIND_MOVE);
    b.target = t;
    send_beat(b);
  endtask

  task automatic link_reset();
    send_beat(rand_beat(KIND_RESET));
  endtask

  // Reset the link, then walk legal moves up to s.
  task automatic walk_to(input link_state_t s);
    link_reset();
    if (s == ST_CLSD) begin
      move_to(ST_CLSD);
    end else if (s != ST_IDLE) begin
      for (int t = 1; t <= 4 && t <= s; t++) move_to(4'(t));
      if (s > ST_ESTB) move_to(s);
    end
  endtask

  task automatic random_move();
    logic [8:0] moves;
    int opts[$];
    lsc_beat_t b;
    b = rand_beat(KIND_MOVE);
    if ($urandom_range(0, 3) != 0) begin
      moves = reachable(m_state);
      // lean toward staying in the working states
      for (int t = 1; t < 8; t++) if (moves[t]) opts.push_back(t);
      if (opts.size() == 0 || $urandom_range(0, 4) == 0)
        for (int t = 0; t < 9; t++) if (moves[t]) opts.push_back(t);
      b.target = 4'(opts[$urandom_range(0, opts.size() - 1)]);
    end
    send_beat(b);
  endtask

  // One install or authorize run of n digest beats; authorize bytes follow the held digest.
  task automatic send_run(input kind_t k, input logic [7:0] mj, input logic [31:0] id,
                          input logic [31:0] gn, input logic [7:0] sz, input int n,
                          input int bad_pos, input int mix_pct);
    lsc_beat_t b;
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 99) < mix_pct) begin
        if ($urandom_range(0, 4) == 0) link_reset();
        else random_move();
      end
      b = rand_beat(k);
      b.major = mj;
      b.id    = id;
      b.gen   = gn;
      b.size  = sz;
      b.last  = (i == n - 1);
      if (k == KIND_AUTH && i < DIG_MAX) b.dbyte = m_dig[i];
      if (i == bad_pos) b.dbyte = b.dbyte ^ (8'h1 << $urandom_range(0, 7));
      send_beat(b);
    end
  endtask

  // Authorize with the held key; n < 0 means as many bytes as the presented size.
  task automatic auth_held(input int n, input int bad_pos, input int tweak, input int mix_pct);
    logic [7:0]  mj;
    logic [31:0] id;
    logic [31:0] gn;
    logic [7:0]  sz;
    mj = {4'b0, m_major};
    id = m_id;
    gn = m_gen;
    sz = m_len;
    case (tweak)
      TW_MAJOR: mj = mj ^ (8'h1 << $urandom_range(0, 7));
      TW_ID:    id = id ^ (32'h1 << $urandom_range(0, 31));
      TW_GEN:   gn = gn ^ (32'h1 << $urandom_range(0, 31));
      TW_SIZE:  sz = sz + 8'd1;
      default:  ;
    endcase
    if (n < 0) n = int'(sz);
    if (n < 1) n = 1;
    send_run(KIND_AUTH, mj, id, gn, sz, n, bad_pos, mix_pct);
  endtask

  task automatic drain_replies();
    while (expected_replies.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_major_mask(input logic [15:0] v);
    in_tvalid <= 1'b0;
    drain_replies();
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    m_mask = v;
    mask_writes++;
  endtask

  task automatic test_link_moves();
    link_reset();
    move_to(ST_CAPS);              // not reachable from idle
    move_to(4'd9);                 // unknown targets
    move_to(4'd15);
    move_to(ST_CLSD);
    move_to(ST_CLSD);              // closed only goes back to idle
    move_to(ST_IDLE);
    move_to(ST_DISC);
    move_to(ST_IDLE);
    move_to(ST_DISC);
    move_to(ST_CAPS);
    move_to(ST_NEGO);
    move_to(ST_ESTB);
    move_to(ST_ADPT);
    move_to(ST_HOFF);
    move_to(ST_ESTB);
    move_to(ST_FALL);
    move_to(ST_ESTB);
    move_to(ST_FALL);
    move_to(ST_DISC);
    link_reset();
  endtask

  task automatic test_install_checks();
    link_reset();
    send_run(KIND_INSTALL, 8'd3, $urandom, $urandom, 8'd4, 4, -1, 0);
    walk_to(ST_DISC);
    send_run(KIND_INSTALL, 8'd3, $urandom, $urandom, 8'd4, 4, -1, 0);
    walk_to(ST_ESTB);
    // two full-size installs so every digest slot holds a written byte
    send_run(KIND_INSTALL, 8'd15, 32'hFFFF_FFFF, 32'h0, 8'(DIG_MAX), DIG_MAX, -1, 0);
    send_run(KIND_INSTALL, 8'd0, 32'h0, 32'hFFFF_FFFF, 8'(DIG_MAX), DIG_MAX, -1, 0);
    send_run(KIND_INSTALL, 8'd16, $urandom, $urandom, 8'd4, 4, -1, 0);
    send_run(KIND_INSTALL, 8'd255, $urandom, $urandom, 8'd4, 4, -1, 0);
    send_run(KIND_INSTALL, 8'd1, $urandom, $urandom, 8'd0, 1, -1, 0);
    send_run(KIND_INSTALL, 8'd1, $urandom, $urandom, 8'(DIG_MAX + 1), DIG_MAX + 1, -1, 0);
    send_run(KIND_INSTALL, 8'd1, $urandom, $urandom, 8'd255, 3, -1, 0);
    send_run(KIND_INSTALL, 8'd2, $urandom, $urandom, 8'd8, 7, -1, 0);
    send_run(KIND_INSTALL, 8'd2, $urandom, $urandom, 8'd8, 9, -1, 0);
    // byte count saturates: 257 bytes must not look like one
    send_run(KIND_INSTALL, 8'd2, $urandom, $urandom, 8'd1, 257, -1, 0);
    walk_to(ST_ESTB);
    send_run(KIND_INSTALL, 8'd9, $urandom, $urandom, 8'd6, 6, -1, 40);
    walk_to(ST_HOFF);
    send_run(KIND_INSTALL, 8'd7, $urandom, $urandom, 8'd1, 1, -1, 0);
  endtask

  task automatic test_authorize();
    lsc_beat_t b;
    walk_to(ST_ADPT);
    send_run(KIND_INSTALL, 8'd4, $urandom, $urandom, 8'd6, 6, -1, 0);
    auth_held(-1, -1, TW_NONE, 0);
    auth_held(-1, 0, TW_NONE, 0);
    auth_held(-1, 5, TW_NONE, 0);
    auth_held(5, -1, TW_NONE, 0);
    auth_held(7, -1, TW_NONE, 0);
    auth_held(-1, -1, TW_MAJOR, 0);
    auth_held(-1, -1, TW_ID, 0);
    auth_held(-1, -1, TW_GEN, 0);
    auth_held(-1, -1, TW_SIZE, 0);
    send_run(KIND_AUTH, {4'b0, m_major}, m_id, m_gen, 8'd0, 1, -1, 0);
    // install and authorize beats share one run counter
    b = rand_beat(KIND_INSTALL);
    b.last = 1'b0;
    send_beat(b);
    auth_held(-1, -1, TW_NONE, 0);
    b = rand_beat(KIND_AUTH);
    b.last = 1'b0;
    send_beat(b);
    send_run(KIND_INSTALL, 8'd4, $urandom, $urandom, 8'd3, 2, -1, 0);
    // fallback back to discovered drops the context
    move_to(ST_FALL);
    auth_held(-1, -1, TW_NONE, 0);
    move_to(ST_DISC);
    send_run(KIND_AUTH, 8'd4, $urandom, $urandom, 8'd6, 6, -1, 0);
    walk_to(ST_ESTB);
    send_run(KIND_INSTALL, 8'd11, $urandom, $urandom, 8'd2, 2, -1, 0);
    move_to(ST_CLSD);
    auth_held(2, -1, TW_NONE, 0);
    link_reset();
  endtask

  task automatic test_major_mask();
    set_major_mask(16'h0000);
    walk_to(ST_NEGO);
    send_run(KIND_INSTALL, 8'd0, $urandom, $urandom, 8'd2, 2, -1, 0);
    send_run(KIND_INSTALL, 8'd15, $urandom, $urandom, 8'd2, 2, -1, 0);
    send_run(KIND_INSTALL, 8'd16, $urandom, $urandom, 8'd2, 2, -1, 0);
    set_major_mask(16'h8000);
    send_run(KIND_INSTALL, 8'd15, $urandom, $urandom, 8'd2, 2, -1, 0);
    auth_held(-1, -1, TW_NONE, 0);
    set_major_mask(16'h0020);
    send_run(KIND_INSTALL, 8'd4, $urandom, $urandom, 8'd3, 3, -1, 0);
    send_run(KIND_INSTALL, 8'd5, $urandom, $urandom, 8'd3, 3, -1, 0);
    auth_held(-1, -1, TW_NONE, 0);
    set_major_mask(16'hFFFF);
  endtask

  task automatic random_install();
    logic [7:0] mj;
    logic [7:0] sz;
    int pick;
    int n;
    if ($urandom_range(0, 9) == 0) mj = 8'($urandom);
    else mj = 8'($urandom_range(0, 15));
    pick = $urandom_range(0, 9);
    if (pick < 6) sz = 8'($urandom_range(1, 8));
    else if (pick < 9) sz = 8'($urandom_range(1, DIG_MAX));
    else sz = 8'($urandom);
    if (sz == 0 || sz > DIG_MAX) n = $urandom_range(1, DIG_MAX + 4);
    else if ($urandom_range(0, 4) == 0) n = ($urandom_range(0, 1) != 0) ? sz + 1 : sz - 1;
    else n = int'(sz);
    if (n < 1) n = 1;
    send_run(KIND_INSTALL, mj, $urandom, $urandom, sz, n, -1, 5);
  endtask

  task automatic random_authorize();
    int pick;
    int n;
    if (m_ctx && $urandom_range(0, 4) != 0) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0: auth_held(-1, -1, TW_MAJOR, 5);
        1: auth_held(-1, -1, TW_ID, 5);
        2: auth_held(-1, -1, TW_GEN, 5);
        3: auth_held(-1, -1, TW_SIZE, 5);
        4: auth_held(-1, $urandom_range(0, m_len - 1), TW_NONE, 5);
        5: begin
          n = ($urandom_range(0, 1) != 0) ? m_len + 1 : m_len - 1;
          if (n < 1) n = 2;
          auth_held(n, -1, TW_NONE, 5);
        end
        default: auth_held(-1, -1, TW_NONE, 5);
      endcase
    end else begin
      send_run(KIND_AUTH, 8'($urandom_range(0, 15)), $urandom, $urandom,
               8'($urandom_range(1, 8)), $urandom_range(1, 8), -1, 5);
    end
  endtask

  task automatic test_random_traffic();
    logic [15:0] mask_val;
    lsc_beat_t b;
    int stop_at;
    int phase_end;
    int phase;
    int pick;
    stop_at = beats_sent + RANDOM_BEATS;
    phase = 0;
    while (beats_sent < stop_at) begin
      case (phase % 5)
        0: mask_val = 16'($urandom);
        1: mask_val = 16'hFFFF;
        2: mask_val = 16'h1 << $urandom_range(0, 15);
        3: mask_val = 16'hFFFF;
        default: mask_val = 16'h0000;
      endcase
      set_major_mask(mask_val);
      gaps_en = (phase != 1);      // one phase runs at full rate on both sides
      phase_end = beats_sent + PHASE_BEATS;
      while (beats_sent < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          random_move();
        end else if (pick < 33) begin
          link_reset();
        end else if (pick < 63) begin
          random_install();
        end else if (pick < 93) begin
          random_authorize();
        end else begin
          // stray digest beat left open in the run counter
          b = rand_beat(($urandom_range(0, 1) != 0) ? KIND_INSTALL : KIND_AUTH);
          b.last = 1'b0;
          send_beat(b);
        end
      end
      phase++;
    end
    gaps_en = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < DIG_MAX; i++) begin
      m_dig[i]   = '0;
      m_stage[i] = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_link_moves();
    test_install_checks();
    test_authorize();
    test_major_mask();
    test_random_traffic();

    in_tvalid <= 1'b0;
    drain_replies();
    $display("Sent %0d input beats, checked %0d replies, wrote the major mask %0d times.",
             beats_sent, replies_checked, mask_writes);
    $display("Accepted installs: %0d, matching authorizes: %0d, mismatches: %0d.",
             installs_ok, auths_ok, mismatch_count);
    if (mismatch_count == 0 && expected_replies.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/lsc_pkg.sv
hdl/lsc_digest_store.sv
hdl/link_session_controller_unit.sv
hdl/lsc_checker.sv
dv/link_session_controller_unit_test.sv
